// File: hdl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// shared types and constants of the compact-size varint parser
// ----------------------------------------------------------------------------
package csvp_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEFT_W  = 4;
    localparam int unsigned POS_W   = 3;

    // first header byte that announces a body
    localparam logic [7:0] HDR_LONG = 8'hFD;
    // last body position that still lands inside the 32-bit value
    localparam logic [POS_W-1:0] MAX_POS = 3'd3;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_UNSUP   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   decoded_value;
        logic                 consumed;
        logic                 not_started;
    } t_result;

endpackage

// File: hdl/compact_size_varint_parser_top.sv
// ----------------------------------------------------------------------------
// compact_size_varint_parser_top
// byte-serial decoder of compact-size variable-length integers
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_stall) takes one raw byte per transaction,
//   with i_start_req to restart the parse at the header phase and
//   i_last_of_chunk as a host marker that does not affect decoding
//   output channel (o_valid / i_stall) gives one result transaction per
//   input byte: status, value so far, consumed flag, not-started flag
//   path: an accepted byte is registered in the input stage; the parser
//   state and the result register update together once the result stage
//   can advance, and the result is shown from then on
//   throughput: one byte per cycle while i_stall is low, set by the state
//   update between the input register and the result register
//   stall: while the result waits under i_stall, the input stage still
//   takes one more byte; o_stall rises only once both stages are full
//   reset: synchronous, active low; parser returns to header phase with a
//   zero value and both stages are emptied
// ----------------------------------------------------------------------------
module compact_size_varint_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    input  logic        i_last_of_chunk,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_decoded_value,
    output logic        o_consumed,
    output logic        o_not_started
);

    // input stage
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;

    // result stage
    logic              r_out_valid;
    csvp_pkg::t_result r_out;

    csvp_pkg::t_result c_result;
    logic              c_advance;
    logic              c_accept;

    // result stage frees when empty or when its transaction completes
    assign c_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !c_advance;
    assign c_accept  = i_valid && !o_stall;

    // parser: state moves only when the byte lands in the result stage
    csvp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_in_valid && c_advance),
        .i_data_byte (r_in_byte),
        .i_start_req (r_in_start),
        .o_result    (c_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (c_accept) begin
            r_in_valid <= 1'b1;
        end else if (c_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // chunk marker has no bearing on decoding and is not stored
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_advance && r_in_valid) begin
            r_out <= c_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_decoded_value = r_out.decoded_value;
    assign o_consumed      = r_out.consumed;
    assign o_not_started   = r_out.not_started;

endmodule

// File: hdl/csvp_core.sv
// ----------------------------------------------------------------------------
// csvp_core
// parser state registers and the per-byte update
// ----------------------------------------------------------------------------
module csvp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_req,
    output csvp_pkg::t_result o_result
);

    csvp_pkg::t_phase                  r_phase, n_phase;
    logic [csvp_pkg::LEFT_W-1:0]       r_left, n_left;
    logic [csvp_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [csvp_pkg::VALUE_W-1:0]      r_acc, n_acc;
    logic                              r_err_inv, n_err_inv;
    logic                              n_took;

    // state as seen by this byte, after an optional start request
    csvp_pkg::t_phase                  c_phase;
    logic [csvp_pkg::LEFT_W-1:0]       c_left;
    logic [csvp_pkg::POS_W-1:0]        c_pos;
    logic [csvp_pkg::VALUE_W-1:0]      c_acc;
    logic                              c_err_inv;
    logic [csvp_pkg::VALUE_W-1:0]      c_shifted;
    logic [csvp_pkg::LEFT_W-1:0]       c_left_dec;

    assign c_phase   = i_start_req ? csvp_pkg::PH_HEADER : r_phase;
    assign c_left    = i_start_req ? '0 : r_left;
    assign c_pos     = i_start_req ? '0 : r_pos;
    assign c_acc     = i_start_req ? '0 : r_acc;
    assign c_err_inv = i_start_req ? 1'b0 : r_err_inv;

    assign c_shifted  = {24'd0, i_data_byte} << {c_pos[1:0], 3'b000};
    assign c_left_dec = c_left - 4'd1;

    // next state
    always_comb begin
        n_phase   = c_phase;
        n_left    = c_left;
        n_pos     = c_pos;
        n_acc     = c_acc;
        n_err_inv = c_err_inv;
        n_took    = 1'b0;
        case (c_phase)
            csvp_pkg::PH_HEADER: begin
                n_took = 1'b1;
                if (i_data_byte < csvp_pkg::HDR_LONG) begin
                    n_acc   = {24'd0, i_data_byte};
                    n_phase = csvp_pkg::PH_DONE;
                end else begin
                    case (i_data_byte[1:0])
                        2'b01:   n_left = 4'd2;
                        2'b10:   n_left = 4'd4;
                        2'b11:   n_left = 4'd8;
                        default: n_left = 4'd0;
                    endcase
                    n_pos   = '0;
                    n_acc   = '0;
                    n_phase = csvp_pkg::PH_BODY;
                end
            end
            csvp_pkg::PH_BODY: begin
                n_took = 1'b1;
                if (c_pos > csvp_pkg::MAX_POS && i_data_byte != 8'd0) begin
                    n_phase   = csvp_pkg::PH_ERROR;
                    n_err_inv = 1'b0;
                end else begin
                    if (c_pos <= csvp_pkg::MAX_POS) begin
                        n_acc = c_acc + c_shifted;
                    end
                    n_pos  = c_pos + 3'd1;
                    n_left = c_left_dec;
                    if (c_left_dec == 4'd0) begin
                        n_phase = csvp_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                n_phase   = csvp_pkg::PH_ERROR;
                n_err_inv = 1'b1;
            end
        endcase
    end

    // result of this byte
    always_comb begin
        case (n_phase)
            csvp_pkg::PH_DONE:  o_result.status = csvp_pkg::ST_DONE;
            csvp_pkg::PH_ERROR: o_result.status = n_err_inv ? csvp_pkg::ST_INVALID
                                                            : csvp_pkg::ST_UNSUP;
            default:            o_result.status = csvp_pkg::ST_BUSY;
        endcase
        o_result.decoded_value = n_acc;
        o_result.consumed      = n_took;
        o_result.not_started   = (n_phase == csvp_pkg::PH_HEADER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= csvp_pkg::PH_HEADER;
            r_left    <= '0;
            r_pos     <= '0;
            r_acc     <= '0;
            r_err_inv <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_err_inv <= n_err_inv;
        end
    end

endmodule

// File: hdl/csvp_checker.sv
// ----------------------------------------------------------------------------
// csvp_checker
// port-level checks of the compact-size varint parser
// ----------------------------------------------------------------------------
module csvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_decoded_value,
    input logic        o_consumed,
    input logic        o_not_started
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_decoded_value) && $stable(o_consumed))
        else $error("stalled result changed");

    // input stalls only with a result pending
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty result stage");

    // refused byte is exactly the invalid case
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_consumed == (o_status != csvp_pkg::ST_INVALID)))
        else $error("consumed flag disagrees with status");

    // every byte moves the parser out of the header phase
    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_not_started)
        else $error("result still reports header phase");

    // reset empties the result stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind compact_size_varint_parser_top csvp_checker u_csvp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_decoded_value (o_decoded_value),
    .o_consumed      (o_consumed),
    .o_not_started   (o_not_started)
);

// File: tb/compact_size_varint_parser_top_tb.sv
// ----------------------------------------------------------------------------
// compact_size_varint_parser_top_tb
// self-checking bench for the byte-serial compact-size varint decoder
// ----------------------------------------------------------------------------
// a queue of bytes filled up front feeds a clocked driver that sends them in
// bursts; every accepted byte runs through a local decoder that predicts the
// result transaction, and a clocked monitor checks each result field by field
// against the oldest prediction. a directed part hits short values, every
// long form, the 32-bit limit, restarts and misuse; a random part then sends
// mostly well-formed integers with random bodies, mixed with broken and
// stray bytes. the receiver stalls on its own pattern, holds off once for a
// long stretch, and the sender pauses twice until all results are back.
// ----------------------------------------------------------------------------
module compact_size_varint_parser_top_tb;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RAND_BYTES    = 1000;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned HOLD_AT_BYTE  = 450;
    localparam int unsigned PAUSE_AT_BYTE = 600;
    localparam int unsigned END_CYCLES    = 8;

    // one pending byte, or a marker that makes the sender wait for a drain
    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       last;
        logic       pause;
    } t_byte_item;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_start_req     = 1'b0;
    logic        i_last_of_chunk = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_decoded_value;
    logic        o_consumed;
    logic        o_not_started;

    t_byte_item         pending_bytes[$];
    csvp_pkg::t_result  expected_results[$];

    // local copy of the parser state
    csvp_pkg::t_phase   dec_phase   = csvp_pkg::PH_HEADER;
    logic [3:0]         dec_left    = '0;
    logic [2:0]         dec_pos     = '0;
    logic [31:0]        dec_value   = '0;
    logic               dec_invalid = 1'b0;

    // handshake bookkeeping shared between the processes
    logic        byte_taken  = 1'b0;
    logic        drain_wait  = 1'b0;
    logic        holding_off = 1'b0;

    int unsigned err_cnt      = 0;
    int unsigned bytes_in     = 0;
    int unsigned results_seen = 0;
    int unsigned n_done       = 0;
    int unsigned n_unsup      = 0;
    int unsigned n_invalid    = 0;
    int unsigned cyc          = 0;

    compact_size_varint_parser_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_req     (i_start_req),
        .i_last_of_chunk (i_last_of_chunk),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_decoded_value (o_decoded_value),
        .o_consumed      (o_consumed),
        .o_not_started   (o_not_started)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // decoder: advances the local state by one byte and gives its result
    // ------------------------------------------------------------------------
    function automatic csvp_pkg::t_result decode_byte(input logic [7:0] b,
                                                      input logic start);
        csvp_pkg::t_result r;
        logic              took;
        took = 1'b0;
        // a start request wipes everything before the byte is looked at
        if (start) begin
            dec_phase   = csvp_pkg::PH_HEADER;
            dec_left    = '0;
            dec_pos     = '0;
            dec_value   = '0;
            dec_invalid = 1'b0;
        end
        case (dec_phase)
            csvp_pkg::PH_HEADER: begin
                took = 1'b1;
                if (b < csvp_pkg::HDR_LONG) begin
                    // short form, the header is the value
                    dec_value = {24'd0, b};
                    dec_phase = csvp_pkg::PH_DONE;
                end else begin
                    // 0xfd, 0xfe, 0xff announce 2, 4, 8 body bytes
                    dec_left  = 4'd2 << 2'(b - csvp_pkg::HDR_LONG);
                    dec_pos   = '0;
                    dec_value = '0;
                    dec_phase = csvp_pkg::PH_BODY;
                end
            end
            csvp_pkg::PH_BODY: begin
                took = 1'b1;
                if (dec_pos > csvp_pkg::MAX_POS && b != 8'd0) begin
                    // value would not fit in 32 bits, the byte is still taken
                    dec_phase   = csvp_pkg::PH_ERROR;
                    dec_invalid = 1'b0;
                end else begin
                    // little endian; zero bytes past the limit add nothing
                    if (dec_pos <= csvp_pkg::MAX_POS)
                        dec_value = dec_value + ({24'd0, b} << {dec_pos, 3'b000});
                    dec_pos  = dec_pos + 3'd1;
                    dec_left = dec_left - 4'd1;
                    if (dec_left == 4'd0)
                        dec_phase = csvp_pkg::PH_DONE;
                end
            end
            default: begin
                // byte after done or an error is refused
                dec_phase   = csvp_pkg::PH_ERROR;
                dec_invalid = 1'b1;
            end
        endcase
        if (dec_phase == csvp_pkg::PH_DONE)
            r.status = csvp_pkg::ST_DONE;
        else if (dec_phase == csvp_pkg::PH_ERROR)
            r.status = dec_invalid ? csvp_pkg::ST_INVALID : csvp_pkg::ST_UNSUP;
        else
            r.status = csvp_pkg::ST_BUSY;
        r.decoded_value = dec_value;
        r.consumed      = took;
        r.not_started   = (dec_phase == csvp_pkg::PH_HEADER);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0d: %s", cyc, what);
        err_cnt++;
    endtask

    task automatic add_byte(input logic [7:0] data, input logic start);
        t_byte_item it;
        it.data  = data;
        it.start = start;
        it.last  = 1'($urandom_range(0, 1));
        it.pause = 1'b0;
        pending_bytes.push_back(it);
    endtask

    task automatic add_pause();
        t_byte_item it;
        it.data  = 8'd0;
        it.start = 1'b0;
        it.last  = 1'b0;
        it.pause = 1'b1;
        pending_bytes.push_back(it);
    endtask

    // ------------------------------------------------------------------------
    // cycle counter and overall timeout
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cyc,
                     expected_results.size());
            $display("compact_size_varint_parser_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks result transactions, then records accepted bytes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        csvp_pkg::t_result want;
        if (!i_rst_n) begin
            byte_taken = 1'b0;
        end else begin
            // results first, a byte accepted at this edge cannot be among them
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, status %0d",
                                              o_status));
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_decoded_value !== want.decoded_value)
                        report_mismatch($sformatf("value 0x%08h, expected 0x%08h",
                                                  o_decoded_value, want.decoded_value));
                    if (o_consumed !== want.consumed)
                        report_mismatch($sformatf("consumed %0b, expected %0b",
                                                  o_consumed, want.consumed));
                    if (o_not_started !== want.not_started)
                        report_mismatch($sformatf("not_started %0b, expected %0b",
                                                  o_not_started, want.not_started));
                    case (want.status)
                        csvp_pkg::ST_DONE:    n_done++;
                        csvp_pkg::ST_UNSUP:   n_unsup++;
                        csvp_pkg::ST_INVALID: n_invalid++;
                        default: ;
                    endcase
                end
            end
            byte_taken = i_valid && !o_stall;
            if (byte_taken) begin
                expected_results.push_back(decode_byte(i_data_byte, i_start_req));
                bytes_in++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: bursts of bytes with random gaps, pause markers wait for a drain
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        t_byte_item nxt;
        logic       nxt_valid;
        nxt_valid = 1'b0;
        nxt       = '{8'd0, 1'b0, 1'b0, 1'b0};
        // payload only moves once the current transaction went through
        if (i_rst_n && (!i_valid || byte_taken)) begin
            // keep offering while the receiver holds off so the block fills up
            if (holding_off)
                gap_left = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (drain_wait) begin
                if (expected_results.size() == 0)
                    drain_wait <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                nxt = pending_bytes.pop_front();
                if (nxt.pause) begin
                    drain_wait <= 1'b1;
                end else begin
                    nxt_valid = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        // some bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_valid <= nxt_valid;
            if (nxt_valid) begin
                i_data_byte     <= nxt.data;
                i_start_req     <= nxt.start;
                i_last_of_chunk <= nxt.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: segments of random modes, one long hold-off
    // ------------------------------------------------------------------------
    int unsigned hold_cnt  = 0;
    logic        hold_done = 1'b0;
    int unsigned seg_left  = 0;
    int unsigned seg_mode  = 0;

    always @(negedge i_clk) begin
        logic st;
        st = 1'b0;
        if (hold_cnt > 0) begin
            hold_cnt--;
            st = 1'b1;
        end else if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
            hold_cnt  = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            st        = 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 96);
            end else begin
                seg_left--;
            end
            case (seg_mode)
                0: st = 1'b0;                              // free flowing
                1: st = ($urandom_range(0, 3) == 0);       // light stalls
                2: st = ($urandom_range(0, 3) != 0);       // heavy stalls
                default: st = ~i_stall;                    // alternating stalls
            endcase
        end
        holding_off <= (hold_cnt > 0);
        i_stall     <= st;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n_rand;
        int unsigned sel;
        int unsigned hi_idx;
        int unsigned n_body;
        logic [7:0]  hdr;
        logic        paused;
        logic        strt;

        // directed: header right after reset without a start request
        add_byte(8'h00, 1'b0);
        // misuse after done, twice
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFD, 1'b0);
        // largest short form
        add_byte(8'hFC, 1'b1);
        // two byte body, little endian, and its maximum
        add_byte(8'hFD, 1'b1);
        add_byte(8'h34, 1'b0);
        add_byte(8'h12, 1'b0);
        add_byte(8'hFD, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        // four byte body
        add_byte(8'hFE, 1'b1);
        add_byte(8'h78, 1'b0);
        add_byte(8'h56, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'hFF, 1'b0);
        // eight byte body that fits in 32 bits
        add_byte(8'hFF, 1'b1);
        for (int i = 0; i < 4; i++)
            add_byte(8'hFF, 1'b0);
        for (int i = 0; i < 4; i++)
            add_byte(8'h00, 1'b0);
        // eight byte body with a nonzero upper byte, then misuse
        add_byte(8'hFF, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h04, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);
        // restart in the middle of a body
        add_byte(8'hFE, 1'b1);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h05, 1'b1);
        add_pause();

        // random: mostly well-formed integers, some broken ones and strays
        n_rand = 0;
        paused = 1'b0;
        while (n_rand < RAND_BYTES) begin
            sel  = $urandom_range(0, 99);
            strt = ($urandom_range(0, 9) != 0);
            if (sel < 30) begin
                add_byte(8'($urandom_range(0, 8'hFC)), strt);
                n_rand += 1;
            end else if (sel < 88) begin
                hdr    = (sel < 50) ? 8'hFD : (sel < 70) ? 8'hFE : 8'hFF;
                n_body = 2 << (hdr - csvp_pkg::HDR_LONG);
                // now and then one upper byte of a long body is nonzero
                hi_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : 0;
                add_byte(hdr, strt);
                for (int i = 0; i < n_body; i++) begin
                    if (i < 4)
                        add_byte(8'($urandom), 1'b0);
                    else if (i == hi_idx)
                        add_byte(8'($urandom_range(1, 255)), 1'b0);
                    else
                        add_byte(8'h00, 1'b0);
                end
                n_rand += n_body + 1;
            end else if (sel < 94) begin
                // truncated long form, the next start cuts it off
                hdr    = 8'($urandom_range(8'hFD, 8'hFF));
                n_body = $urandom_range(0, (2 << (hdr - csvp_pkg::HDR_LONG)) - 1);
                add_byte(hdr, strt);
                for (int i = 0; i < n_body; i++)
                    add_byte(8'($urandom), 1'b0);
                n_rand += n_body + 1;
            end else begin
                // stray bytes with no start request
                n_body = $urandom_range(1, 3);
                for (int i = 0; i < n_body; i++)
                    add_byte(8'($urandom), 1'b0);
                n_rand += n_body;
            end
            // occasional trailing byte after the integer
            if ($urandom_range(0, 9) == 0) begin
                add_byte(8'($urandom), 1'b0);
                n_rand += 1;
            end
            if (!paused && n_rand >= PAUSE_AT_BYTE) begin
                add_pause();
                paused = 1'b1;
            end
        end

        // hold reset, then release it between edges
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait until everything was sent and every result came back
        while (pending_bytes.size() != 0 || i_valid || drain_wait
               || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes and %0d results: %0d done, %0d unsupported, %0d invalid",
                 bytes_in, results_seen, n_done, n_unsup, n_invalid);
        $display("with one long receiver hold-off, two full drains and %0d mismatches",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("compact_size_varint_parser_top test passed");
        end else begin
            $display("compact_size_varint_parser_top test failed");
        end
        $finish;
    end

endmodule
